// ----- sv/serial_byte_framer_assert.svh -----
// Assertion macros shared by the serial byte framer RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SERIAL_BYTE_FRAMER_ASSERT_SVH
`define SERIAL_BYTE_FRAMER_ASSERT_SVH

`define SBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sbf_pkg.sv -----
// Package for the serial byte framer: defaults, codes, state and bus types, and delimiter helper functions.
// Used by every module of the block but sbf_ram; depends on nothing.
package sbf_pkg;

    localparam int BUFFER_DEPTH_DEF    = 256;
    localparam int FIXED_FRAME_MAX_DEF = 256;
    localparam int DELIMITER_MAX_DEF   = 4;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_DELIM = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_SIZE    = 3'd1;
    localparam logic [2:0] REG_PATTERN = 3'd2;
    localparam logic [2:0] REG_DLEN    = 3'd3;
    localparam logic [2:0] REG_LIMIT   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PACK,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic read_en;
        logic pack_en;
        logic put_en;
    } cmd_t;

    typedef struct packed {
        logic need_drain;
        logic piece_full;
        logic frame_done;
        logic out_free;
    } stat_t;

    function automatic logic [2:0] eff_delim_len(logic [2:0] dl, logic [2:0] cap);
        logic [2:0] l;
        l = (dl == 3'd0) ? 3'd1 : dl;
        if (l > cap)
        begin
            l = cap;
        end
        return l;
    endfunction

    function automatic logic delim_match(logic [31:0] recent, logic [31:0] pat,
                                         logic [2:0] len);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if ((3'(k) < len) && (3'(j) == len - 3'd1 - 3'(k)) &&
                    (recent[8*k +: 8] != pat[8*j +: 8]))
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// ----- sv/sbf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used by the framer datapath for the frame store.
module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/sbf_ctrl.sv -----
// Framer controller: input handshake and the frame drain sequence.
// Depends on sbf_pkg; drives the datapath by commands and reads its status.
module sbf_ctrl
    import sbf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.need_drain)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = ST_PACK;
            end
            ST_PACK:
            begin
                cmd.pack_en = 1'b1;
                state_next  = stat.piece_full ? ST_PUT : ST_READ;
            end
            ST_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put_en = 1'b1;
                    state_next = stat.frame_done ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sbf_datapath.sv -----
// Framer datapath: configuration registers, framing state, frame store,
// piece packing and the output register. Depends on sbf_pkg and sbf_ram.
module sbf_datapath
    import sbf_pkg::*;
#(
    parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
    parameter int FIXED_FRAME_MAX = FIXED_FRAME_MAX_DEF,
    parameter int DELIMITER_MAX   = DELIMITER_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] piece_bytes,
    output logic [3:0]  piece_count,
    output logic        frame_last,
    output logic        overflow
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = (FW > 10) ? FW : 10;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] FMAX_C  = CW'(FIXED_FRAME_MAX);
    localparam logic [2:0]    DCAP    = 3'((DELIMITER_MAX < 4) ? DELIMITER_MAX : 4);

    logic [1:0]  mode_reg;
    logic [8:0]  size_reg;
    logic [31:0] pattern_reg;
    logic [2:0]  dlen_reg;
    logic [8:0]  limit_reg;

    logic [FW-1:0] fill_reg, fill_next;
    logic          disc_reg, disc_next;
    logic [31:0]   recent_reg, recent_next;
    logic [2:0]    seg_reg, seg_next;

    logic [FW-1:0] dlen_cnt_reg, dlen_cnt_next;
    logic [FW-1:0] rd_idx_reg;
    logic [63:0]   piece_reg;
    logic [3:0]    cnt_reg;

    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_bytes_reg, out_bytes_next;
    logic [3:0]    out_cnt_reg, out_cnt_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          cfg_we;
    logic          cfg_hit;
    logic [2:0]    len;
    logic [CW-1:0] lim, size_c, fill_c, f0, f1;
    logic          size_bad;
    logic [31:0]   shifted;
    logic [2:0]    seg_inc;
    logic          store_we;
    logic          need_drain;
    logic [AW-1:0] waddr;
    logic [7:0]    rdata;
    logic [FW-1:0] rd_inc;

    assign cfg_we = psel && penable && pwrite;
    assign cfg_hit = cfg_we && (paddr[4:2] <= REG_LIMIT);

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_SIZE:    prdata = {23'd0, size_reg};
            REG_PATTERN: prdata = pattern_reg;
            REG_DLEN:    prdata = {29'd0, dlen_reg};
            REG_LIMIT:   prdata = {23'd0, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RAW;
            size_reg    <= 9'd16;
            pattern_reg <= 32'd10;
            dlen_reg    <= 3'd1;
            limit_reg   <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_MODE:    mode_reg    <= pwdata[1:0];
                REG_SIZE:    size_reg    <= pwdata[8:0];
                REG_PATTERN: pattern_reg <= pwdata;
                REG_DLEN:    dlen_reg    <= pwdata[2:0];
                REG_LIMIT:   limit_reg   <= pwdata[8:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        len      = eff_delim_len(dlen_reg, DCAP);
        lim      = (limit_reg == 9'd0) ? CW'(1) : CW'(limit_reg);
        if (lim > DEPTH_C)
        begin
            lim = DEPTH_C;
        end
        size_c   = CW'(size_reg);
        fill_c   = CW'(fill_reg);
        size_bad = (size_c == '0) || (size_c > FMAX_C) || (size_c > DEPTH_C);
        shifted  = {recent_reg[23:0], data_byte};
        seg_inc  = (seg_reg == 3'd4) ? 3'd4 : seg_reg + 3'd1;

        if (mode_reg == MODE_FIXED)
        begin
            f0 = ((fill_c >= size_c) || (fill_c >= DEPTH_C)) ? '0 : fill_c;
        end
        else
        begin
            f0 = (fill_c >= DEPTH_C) ? '0 : fill_c;
        end
        f1    = f0 + CW'(1);
        waddr = f0[AW-1:0];

        fill_next      = fill_reg;
        disc_next      = disc_reg;
        recent_next    = recent_reg;
        seg_next       = seg_reg;
        dlen_cnt_next  = dlen_cnt_reg;
        store_we       = 1'b0;
        need_drain     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_bytes_next = out_bytes_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (cmd.accept)
        begin
            if (mode_reg == MODE_RAW)
            begin
                out_valid_next = 1'b1;
                out_bytes_next = {56'd0, data_byte};
                out_cnt_next   = 4'd1;
                out_last_next  = chunk_end;
                out_ovf_next   = 1'b0;
            end
            else if (mode_reg == MODE_FIXED)
            begin
                if (size_bad)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = '0;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b0;
                    out_ovf_next   = 1'b1;
                end
                else
                begin
                    store_we = 1'b1;
                    if (f1 == size_c)
                    begin
                        fill_next     = '0;
                        dlen_cnt_next = FW'(f1);
                        need_drain    = 1'b1;
                    end
                    else
                    begin
                        fill_next = FW'(f1);
                    end
                end
            end
            else if (disc_reg)
            begin
                recent_next = shifted;
                seg_next    = seg_inc;
                if ((seg_inc >= len) && delim_match(shifted, pattern_reg, len))
                begin
                    disc_next   = 1'b0;
                    seg_next    = '0;
                    recent_next = '0;
                end
            end
            else
            begin
                store_we    = 1'b1;
                recent_next = shifted;
                if ((f1 >= CW'(len)) && delim_match(shifted, pattern_reg, len))
                begin
                    fill_next     = '0;
                    dlen_cnt_next = FW'(f1);
                    need_drain    = 1'b1;
                end
                else if (f1 >= lim)
                begin
                    fill_next      = '0;
                    disc_next      = 1'b1;
                    seg_next       = '0;
                    recent_next    = '0;
                    out_valid_next = 1'b1;
                    out_bytes_next = '0;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b0;
                    out_ovf_next   = 1'b1;
                end
                else
                begin
                    fill_next = FW'(f1);
                end
            end
        end

        if (cmd.put_en)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = piece_reg;
            out_cnt_next   = cnt_reg;
            out_last_next  = (rd_idx_reg == dlen_cnt_reg);
            out_ovf_next   = 1'b0;
        end

        if (cfg_hit)
        begin
            fill_next   = '0;
            disc_next   = 1'b0;
            recent_next = '0;
            seg_next    = '0;
        end
    end

    assign rd_inc          = rd_idx_reg + FW'(1);
    assign stat.need_drain = need_drain;
    assign stat.piece_full = (cnt_reg == 4'd7) || (rd_inc == dlen_cnt_reg);
    assign stat.frame_done = (rd_idx_reg == dlen_cnt_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            disc_reg      <= 1'b0;
            recent_reg    <= '0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            disc_reg      <= disc_next;
            recent_reg    <= recent_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
            if (need_drain || cmd.put_en)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.pack_en)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (need_drain)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.pack_en)
            begin
                rd_idx_reg <= rd_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dlen_cnt_reg  <= dlen_cnt_next;
        out_bytes_reg <= out_bytes_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
        if (need_drain || cmd.put_en)
        begin
            piece_reg <= '0;
        end
        else if (cmd.pack_en)
        begin
            piece_reg[8*cnt_reg[2:0] +: 8] <= rdata;
        end
    end

    sbf_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(waddr),
        .wdata(data_byte),
        .re   (cmd.read_en),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign out_valid   = out_valid_reg;
    assign piece_bytes = out_bytes_reg;
    assign piece_count = out_cnt_reg;
    assign frame_last  = out_last_reg;
    assign overflow    = out_ovf_reg;

endmodule

// ----- sv/serial_byte_framer.sv -----
// Top level of the serial byte framer: controller plus datapath.
// Depends on sbf_pkg, sbf_ctrl, sbf_datapath and serial_byte_framer_assert.svh.
//
// Bytes enter one word at a time on the data_byte/chunk_end channel and leave
// as pieces of up to eight frame bytes on the piece channel; both channels
// use valid/ready. The user must set the mode and framing limits over the APB
// port while the block is idle; the block does not enforce this. A write to any
// of the five configuration registers restarts framing. In raw mode, and for a
// status word, the result is registered in the cycle after the input word is
// taken, so one byte per cycle flows while the receiver keeps up. A byte that
// completes a fixed or delimited frame starts a drain from the frame store,
// which has one registered read port: each byte passes a read and a pack state,
// each piece a put state, and no input word is taken meanwhile. Other bytes are
// stored as taken, but not while a frame is discarded or the fixed size is bad.
// When the receiver stalls, the output register holds its word and input is
// refused until it drains. After reset the block is in raw mode, with no
// framing state held; the frame store needs no clearing.
`include "serial_byte_framer_assert.svh"

module serial_byte_framer
    import sbf_pkg::*;
#(
    parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
    parameter int FIXED_FRAME_MAX = FIXED_FRAME_MAX_DEF,
    parameter int DELIMITER_MAX   = DELIMITER_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] piece_bytes,
    output logic [3:0]  piece_count,
    output logic        frame_last,
    output logic        overflow
);

    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    sbf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sbf_datapath #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .FIXED_FRAME_MAX(FIXED_FRAME_MAX),
        .DELIMITER_MAX  (DELIMITER_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .data_byte  (data_byte),
        .chunk_end  (chunk_end),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .piece_bytes(piece_bytes),
        .piece_count(piece_count),
        .frame_last (frame_last),
        .overflow   (overflow)
    );

    `SBF_ASSERT_NOW(a_status_empty, out_valid && overflow, piece_count == 4'd0 && !frame_last, "status word carries data")
    `SBF_ASSERT_NOW(a_data_count, out_valid && !overflow, piece_count != 4'd0 && piece_count <= 4'd8, "data word count out of range")
    `SBF_ASSERT_NEXT(a_drain_blocks, cmd.accept && stat.need_drain, !in_ready, "input taken during frame drain")

endmodule

// ----- bench/serial_byte_framer_tb.sv -----
// Self-checking testbench for serial_byte_framer: raw, fixed and delimited framing.
// Depends on sbf_pkg and the serial_byte_framer RTL; predicts every piece word and
// checks it field by field against the block's output channel.
`timescale 1ns / 1ps

module serial_byte_framer_tb;
    import sbf_pkg::*;

    localparam int DEPTH    = 256;
    localparam int SIZE_MAX = 256;
    localparam int DLEN_MAX = 4;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic        ovf;
    } piece_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] piece_bytes;
    logic [3:0]  piece_count;
    logic        frame_last;
    logic        overflow;

    serial_byte_framer uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .chunk_end(chunk_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .piece_bytes(piece_bytes), .piece_count(piece_count),
        .frame_last(frame_last), .overflow(overflow)
    );

    // Predictor state and configuration.
    logic [1:0]  mode_q;
    logic [8:0]  size_q;
    logic [31:0] pattern_q;
    logic [2:0]  dlen_q;
    logic [8:0]  limit_q;
    logic [7:0]  store_q [DEPTH];
    int          fill_q;
    bit          discard_q;
    logic [31:0] recent_q;
    int          seg_q;

    piece_t      pending_pieces[$];
    int          error_count;
    int          cycle_count;
    bit          stall_out;
    int          stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("serial_byte_framer_tb: done, errors");
            $finish;
        end
    end

    task automatic clear_framing();
        fill_q    = 0;
        discard_q = 0;
        recent_q  = '0;
        seg_q     = 0;
    endtask

    task automatic queue_piece(piece_t p);
        pending_pieces = {pending_pieces, p};
    endtask

    task automatic queue_frame(int n);
        piece_t p;
        for (int off = 0; off < n; off += 8)
        begin
            p = '0;
            p.count = 4'((n - off < 8) ? n - off : 8);
            for (int i = 0; i < p.count; i++)
            begin
                p.bytes[8*i +: 8] = store_q[off + i];
            end
            p.last = (off + p.count >= n);
            queue_piece(p);
        end
    endtask

    task automatic queue_status();
        piece_t p;
        p = '0;
        p.ovf = 1'b1;
        queue_piece(p);
    endtask

    function automatic int delimiter_span();
        int l;
        l = (dlen_q == 0) ? 1 : int'(dlen_q);
        if (l > DLEN_MAX) l = DLEN_MAX;
        return l;
    endfunction

    function automatic logic [7:0] delimiter_at(int i);
        return pattern_q[8*(i % 4) +: 8];
    endfunction

    task automatic predict_word(logic [7:0] b, logic ce);
        piece_t p;
        int len;
        int lim;
        bit hit;
        if (mode_q == MODE_RAW)
        begin
            p = '0;
            p.bytes[7:0] = b;
            p.count = 4'd1;
            p.last = ce;
            queue_piece(p);
        end
        else if (mode_q == MODE_FIXED)
        begin
            if (size_q == 0 || size_q > SIZE_MAX || size_q > DEPTH)
            begin
                queue_status();
            end
            else
            begin
                if (fill_q >= size_q || fill_q >= DEPTH) fill_q = 0;
                store_q[fill_q] = b;
                fill_q++;
                if (fill_q == size_q)
                begin
                    queue_frame(size_q);
                    fill_q = 0;
                end
            end
        end
        else
        begin
            len = delimiter_span();
            lim = (limit_q == 0) ? 1 : int'(limit_q);
            if (lim > DEPTH) lim = DEPTH;
            if (discard_q)
            begin
                recent_q = {recent_q[23:0], b};
                if (seg_q < 4) seg_q++;
                if (seg_q >= len)
                begin
                    hit = 1;
                    for (int k = 0; k < len; k++)
                        if (recent_q[8*k +: 8] != delimiter_at(len - 1 - k)) hit = 0;
                    if (hit) clear_framing();
                end
            end
            else
            begin
                if (fill_q >= DEPTH) fill_q = 0;
                store_q[fill_q] = b;
                fill_q++;
                hit = 0;
                if (fill_q >= len)
                begin
                    hit = 1;
                    for (int k = 0; k < len; k++)
                        if (store_q[fill_q - 1 - k] != delimiter_at(len - 1 - k)) hit = 0;
                end
                if (hit)
                begin
                    queue_frame(fill_q);
                    fill_q = 0;
                end
                else if (fill_q >= lim)
                begin
                    fill_q = 0;
                    discard_q = 1;
                    seg_q = 0;
                    recent_q = '0;
                    queue_status();
                end
            end
        end
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(negedge clk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_drained();
        while (pending_pieces.size() != 0) @(negedge clk);
        idle_cycles(20);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        while (pending_pieces.size() != 0) @(negedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:    mode_q    = value[1:0];
            REG_SIZE:    size_q    = value[8:0];
            REG_PATTERN: pattern_q = value;
            REG_DLEN:    dlen_q    = value[2:0];
            REG_LIMIT:   limit_q   = value[8:0];
            default: ;
        endcase
        clear_framing();
    endtask

    // Drives one word; with gap set, a random idle precedes it.
    task automatic send_word(logic [7:0] b, logic ce, bit gap = 1);
        if (gap) idle_cycles(random_gap());
        in_valid  = 1'b1;
        data_byte = b;
        chunk_end = ce;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(b, ce);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_delimiter(int len);
        for (int i = 0; i < len; i++) send_word(delimiter_at(i), 1'($urandom));
    endtask

    task automatic send_junk(int n);
        for (int i = 0; i < n; i++) send_word(8'($urandom), 1'($urandom));
    endtask

    always @(posedge clk)
    begin
        piece_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pieces.size() == 0)
            begin
                $error("unexpected word: bytes %h count %0d", piece_bytes, piece_count);
                error_count++;
            end
            else
            begin
                want = pending_pieces.pop_front();
                if (piece_bytes !== want.bytes)
                begin
                    $error("piece_bytes: expected %h, actual %h", want.bytes, piece_bytes);
                    error_count++;
                end
                if (piece_count !== want.count)
                begin
                    $error("piece_count: expected %0d, actual %0d", want.count, piece_count);
                    error_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.last, frame_last);
                    error_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0d, actual %0d", want.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!stall_out)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (r < 3)
        begin
            stall_left = $urandom_range(8, 40);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (r >= 30);
        end
    end

    task automatic test_raw();
        write_reg(REG_MODE, MODE_RAW);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b1);
        wait_drained();
    endtask

    task automatic test_fixed_directed();
        write_reg(REG_MODE, MODE_FIXED);
        write_reg(REG_SIZE, 9'd0);
        send_word(8'h11, 1'b0);
        write_reg(REG_SIZE, 9'd511);
        send_word(8'h22, 1'b0);
        write_reg(REG_SIZE, 9'd257);
        send_word(8'h23, 1'b0);
        write_reg(REG_SIZE, 9'd1);
        send_word(8'h33, 1'b0);
        write_reg(REG_SIZE, 9'd9);
        send_junk(9);
        wait_drained();
        write_reg(REG_SIZE, 9'd64);
        send_junk(64);
        wait_drained();
    endtask

    task automatic test_delimited_directed();
        write_reg(REG_MODE, 2'd3);
        write_reg(REG_PATTERN, 32'h0D0A_0D0A);
        write_reg(REG_DLEN, 3'd0);
        write_reg(REG_LIMIT, 9'd0);
        send_word(8'h0A, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h0A, 1'b0);
        wait_drained();
        write_reg(REG_MODE, MODE_DELIM);
        write_reg(REG_PATTERN, 32'hEF_BE_AD_DE);
        write_reg(REG_DLEN, 3'd7);
        write_reg(REG_LIMIT, 9'd511);
        send_word(8'h01, 1'b0);
        send_delimiter(4);
        write_reg(REG_LIMIT, 9'd6);
        send_junk(6);
        send_word(8'hDE, 1'b0);
        send_word(8'hAD, 1'b0);
        send_delimiter(4);
        send_word(8'h55, 1'b0);
        send_delimiter(4);
        wait_drained();
    endtask

    task automatic test_random_fixed(int n);
        int sz;
        for (int ph = 0; ph < 3; ph++)
        begin
            sz = $urandom_range(1, 20);
            write_reg(REG_SIZE, 9'(sz));
            for (int i = 0; i < n / 3; i++) send_word(8'($urandom), 1'($urandom));
            wait_drained();
        end
    endtask

    task automatic test_random_delimited(int frames);
        int len;
        int body;
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_PATTERN, $urandom);
            write_reg(REG_DLEN, 3'($urandom_range(1, 4)));
            write_reg(REG_LIMIT, 9'($urandom_range(4, 24)));
            len = delimiter_span();
            for (int f = 0; f < frames; f++)
            begin
                body = $urandom_range(0, 100) < 85 ? $urandom_range(0, 12) : 30;
                send_junk(body);
                if ($urandom_range(0, 9) < 8) send_delimiter(len);
                else send_delimiter($urandom_range(1, len));
                if (f == frames / 2)
                begin
                    while (pending_pieces.size() != 0) @(negedge clk);
                end
            end
            wait_drained();
        end
    endtask

    task automatic test_raw_random(int n);
        write_reg(REG_MODE, MODE_RAW);
        for (int i = 0; i < n; i++) send_word(8'($urandom), 1'($urandom), i % 20 > 4);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        data_byte = '0;
        chunk_end = 1'b0;
        out_ready = 1'b1;
        stall_out = 1'b0;
        error_count = 0;
        cycle_count = 0;
        mode_q = MODE_RAW;
        size_q = 9'd16;
        pattern_q = 32'd10;
        dlen_q = 3'd1;
        limit_q = 9'd256;
        clear_framing();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_raw();
        stall_out = 1'b1;
        test_fixed_directed();
        test_delimited_directed();
        stall_out = 1'b0;
        test_raw_random(20);
        stall_out = 1'b1;
        write_reg(REG_MODE, MODE_FIXED);
        test_random_fixed(60);
        write_reg(REG_MODE, MODE_DELIM);
        test_random_delimited(3);
        test_raw_random(30);
        while (pending_pieces.size() != 0) @(negedge clk);
        idle_cycles(50);
        if (error_count == 0)
            $display("serial_byte_framer_tb: done, clean");
        else
            $display("serial_byte_framer_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sbf_pkg.sv
sv/sbf_ram.sv
sv/sbf_ctrl.sv
sv/sbf_datapath.sv
sv/serial_byte_framer.sv
bench/serial_byte_framer_tb.sv
